FILE: rtl/brlu_pkg.sv
// brlu_pkg: shared types and constants for the bit run-length byte unpacker.
// No dependencies; used by every module of the block.
`default_nettype none

package brlu_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int LEN_W       = 7;
    localparam int FILL_W      = 3;
    localparam int CNT_W       = 5;   // up to 16 bytes per run
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [LEN_W-1:0]  MAX_RUN     = 7'd127;
    localparam logic [CNT_W-1:0]  MAX_BYTES   = 5'd16;
    localparam logic [QCNT_W-1:0] QUEUE_FULL  = 3'd4;

    // one queued run, length already saturated
    typedef struct packed {
        logic             bit_val;
        logic [LEN_W-1:0] len;
        logic             fin;
    } run_t;

endpackage

`default_nettype wire

FILE: rtl/brlu_front.sv
// brlu_front: accepts runs, clamps the length and queues them for the back end.
// Depends on brlu_pkg.
`default_nettype none

module brlu_front
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        run_bit,
    input  wire logic [brlu_pkg::LEN_W-1:0]  run_length,
    input  wire logic                        final_run,
    output logic                             q_valid,
    input  wire logic                        q_ready,
    output brlu_pkg::run_t                   q_run
);

    brlu_pkg::run_t                    mem [brlu_pkg::QUEUE_DEPTH];
    logic [brlu_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [brlu_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [brlu_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                              push, pop;
    brlu_pkg::run_t                    in_run;

    assign in_ready = (count_reg != brlu_pkg::QUEUE_FULL);
    assign q_valid  = (count_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_run    = mem[rd_ptr_reg];

    always_comb
    begin
        in_run.bit_val = run_bit;
        in_run.len     = (run_length > brlu_pkg::MAX_RUN) ? brlu_pkg::MAX_RUN : run_length;
        in_run.fin     = final_run;

        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_run;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= brlu_pkg::QUEUE_FULL)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == brlu_pkg::QUEUE_FULL) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow the queue");

endmodule

`default_nettype wire

FILE: rtl/brlu_back.sv
// brlu_back: expands queued runs into bytes, one byte per cycle unless out_ready
// stalls the output, through an output register. Depends on brlu_pkg.
`default_nettype none

module brlu_back
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_valid,
    output logic                                    q_ready,
    input  wire brlu_pkg::run_t                     q_run,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [brlu_pkg::BYTE_BITS-1:0]          data_byte,
    output logic                                    last_of_run
);

    logic [brlu_pkg::LEN_W-1:0]     acc_reg, acc_next;
    logic [brlu_pkg::FILL_W-1:0]    fill_reg, fill_next;
    logic [brlu_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           first_reg, first_next;
    logic                           bit_reg, bit_next;
    logic [brlu_pkg::BYTE_BITS-1:0] head_reg, head_next;
    logic                           ov_reg, ov_next;
    logic [brlu_pkg::BYTE_BITS-1:0] db_reg, db_next;
    logic                           last_reg, last_next;

    logic                           emit, pop;
    logic [brlu_pkg::BYTE_BITS-1:0] total;
    logic [brlu_pkg::CNT_W-1:0]     nbytes;
    logic [brlu_pkg::FILL_W-1:0]    rem;
    logic [3:0]                     head_shift;
    logic [brlu_pkg::BYTE_BITS-1:0] head_byte;
    logic [brlu_pkg::LEN_W-1:0]     carry_acc;

    assign emit    = (cnt_reg != '0) && (!ov_reg || out_ready);
    assign q_ready = (cnt_reg == '0) || ((cnt_reg == 5'd1) && emit);
    assign pop     = q_valid && q_ready;

    assign out_valid   = ov_reg;
    assign data_byte   = db_reg;
    assign last_of_run = last_reg;

    always_comb
    begin
        total  = {1'b0, q_run.len} + {5'b0, fill_reg};
        nbytes = total[7:3];
        rem    = total[2:0];

        // held bits go to the top, the rest of the byte is filled with the run bit
        head_shift = 4'd8 - {1'b0, fill_reg};
        head_byte  = ({1'b0, acc_reg} << head_shift)
                   | (q_run.bit_val ? (8'hFF >> fill_reg) : 8'h00);

        if (nbytes != '0)
        begin
            carry_acc = q_run.bit_val ? (7'h7F >> (3'd7 - rem)) : 7'h00;
        end
        else
        begin
            // whole run fits in the partial byte, so len < 8
            carry_acc = (acc_reg << q_run.len[2:0])
                      | (q_run.bit_val ? (7'h7F >> (3'd7 - q_run.len[2:0])) : 7'h00);
        end

        acc_next   = acc_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        bit_next   = bit_reg;
        head_next  = head_reg;
        ov_next    = ov_reg;
        db_next    = db_reg;
        last_next  = last_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        if (emit)
        begin
            ov_next    = 1'b1;
            db_next    = first_reg ? head_reg : {brlu_pkg::BYTE_BITS{bit_reg}};
            last_next  = (cnt_reg == 5'd1);
            first_next = 1'b0;
            cnt_next   = cnt_reg - 1'b1;
        end

        if (pop)
        begin
            cnt_next   = nbytes;
            first_next = 1'b1;
            bit_next   = q_run.bit_val;
            head_next  = head_byte;
            if (q_run.fin)
            begin
                acc_next  = '0;
                fill_next = '0;
            end
            else
            begin
                acc_next  = carry_acc;
                fill_next = rem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            first_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg  <= bit_next;
        head_reg <= head_next;
        db_reg   <= db_next;
        last_reg <= last_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= brlu_pkg::MAX_BYTES)
        else $error("byte count out of range");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid && (last_of_run == ($past(cnt_reg) == 5'd1))))
        else $error("last flag does not match remaining count");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((acc_reg >> fill_reg) == '0))
        else $error("partial bits above fill count");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cnt_reg == '0 || emit))
        else $error("run taken while bytes still pending");

endmodule

`default_nettype wire

FILE: rtl/bit_run_length_byte_unpacker.sv
// The first byte of a run passes through the queue, the expander's head register and the
// output register. Throughput: one byte per cycle unless out_ready stalls; a 127-bit run
// expands to up to 16 bytes; a 4-entry queue absorbs input while the expander works.
// Reset (rst_n, async active low) empties the queue and output, clears partial bits.
// Top level: instantiates brlu_front (accept/queue) and brlu_back (byte expander).
// Depends on brlu_pkg.
`default_nettype none

module bit_run_length_byte_unpacker
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        run_bit,
    input  wire logic [brlu_pkg::LEN_W-1:0]  run_length,
    input  wire logic                        final_run,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [brlu_pkg::BYTE_BITS-1:0]   data_byte,
    output logic                             last_of_run
);

    logic           q_valid;
    logic           q_ready;
    brlu_pkg::run_t q_run;

    brlu_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .run_bit    (run_bit),
        .run_length (run_length),
        .final_run  (final_run),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_run      (q_run)
    );

    brlu_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_run       (q_run),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_byte   (data_byte),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire
